// File: rtl/fnv_pkg.sv
// shared types, constants and helpers for the fnv-1a 64-bit string hash
package fnv_pkg;

  localparam logic [63:0] OFFSET_BASIS = 64'hcbf29ce484222325;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [0:0] REG_NORMALIZE = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       take;
    logic       last;
  } stage_word_t;

  typedef struct packed {
    logic advance;
  } stage_ctrl_t;

  // multiply by the fnv prime 2^40 + 0x1b3, modulo 2^64
  function automatic logic [63:0] mul_prime(input logic [63:0] x);
    logic [63:0] sum;
    begin
      sum = x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
      return sum;
    end
  endfunction

  function automatic logic is_skipped(input logic [7:0] c);
    logic skip;
    begin
      skip = 1'b0;
      if ((c >= 8'h09 && c <= 8'h0d) || c == 8'h20) begin
        skip = 1'b1;
      end
      if ((c >= 8'h21 && c <= 8'h2f) || (c >= 8'h3a && c <= 8'h40)) begin
        skip = 1'b1;
      end
      if ((c >= 8'h5b && c <= 8'h60) || (c >= 8'h7b && c <= 8'h7e)) begin
        skip = 1'b1;
      end
      return skip;
    end
  endfunction

endpackage

// File: rtl/fnv_if.sv
// valid/ready channel interfaces for string bytes and hash results
interface fnv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       no_byte;
  logic       last;

  modport source (output valid, output data_byte, output no_byte, output last, input ready);
  modport sink (input valid, input data_byte, input no_byte, input last, output ready);
endinterface

interface fnv_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

// File: rtl/fnv1a64_string_hash.sv
// top level of the fnv-1a 64-bit string hash with its register port
// Hashes a string given one byte per word on in_ch and returns the 64-bit
// FNV-1a hash on out_ch after the word marked last. A word flagged no_byte
// hashes nothing, so no_byte with last ends an empty string. One word is
// taken every cycle unless the input register is held; a byte waits in the
// input register and is folded into the running hash as it advances, and a
// last word then puts its hash on out_ch through the result register. A last
// word waits in the input register while an earlier hash is still held on
// out_ch. The shift-and-add multiply by the prime lies in the hash register
// loop. Register 0 at byte address 0 is normalize: when set, A-Z are
// lowercased and whitespace and punctuation bytes are dropped.
module fnv1a64_string_hash (
  input  logic                                clk,
  input  logic                                rst_n,
  fnv_in_if.sink                              in_ch,
  fnv_out_if.source                           out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [fnv_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  logic                 normalize_r;
  logic                 normalize_nxt;
  logic                 cfg_write;
  logic                 s1_valid;
  fnv_pkg::stage_word_t s1_word;
  fnv_pkg::stage_ctrl_t ctrl;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    normalize_nxt = normalize_r;
    if (cfg_write && cfg_paddr[2] == fnv_pkg::REG_NORMALIZE) begin
      normalize_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normalize_r <= 1'b0;
    end else begin
      normalize_r <= normalize_nxt;
    end
  end

  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_paddr[2] == fnv_pkg::REG_NORMALIZE) begin
      cfg_prdata = {31'd0, normalize_r};
    end
  end

  fnv_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .normalize (normalize_r),
    .ctrl      (ctrl),
    .s1_valid  (s1_valid),
    .s1_word   (s1_word)
  );

  fnv_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_word  (s1_word),
    .ctrl     (ctrl),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  a_last_emits : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && s1_word.last && ctrl.advance |=> out_ch.valid)
    else $error("last word did not produce a result");

  a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |-> !s1_valid || ctrl.advance)
    else $error("input register overwritten while held");

  a_cfg_write : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_write && cfg_paddr[2] == fnv_pkg::REG_NORMALIZE |=> normalize_r == $past(cfg_pwdata[0]))
    else $error("normalize register write lost");
`endif

endmodule

// File: rtl/fnv_norm.sv
// input stage: byte normalization and the registered input word
module fnv_norm (
  input  logic                clk,
  input  logic                rst_n,
  fnv_in_if.sink              in_ch,
  input  logic                normalize,
  input  fnv_pkg::stage_ctrl_t ctrl,
  output logic                s1_valid,
  output fnv_pkg::stage_word_t s1_word
);

  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  fnv_pkg::stage_word_t s1_word_r;
  fnv_pkg::stage_word_t s1_word_nxt;
  logic [7:0]           lowered;
  logic                 accept;

  assign in_ch.ready = !s1_valid_r || ctrl.advance;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    lowered = in_ch.data_byte;
    if (normalize && in_ch.data_byte >= 8'h41 && in_ch.data_byte <= 8'h5a) begin
      lowered = in_ch.data_byte + 8'h20;
    end
    s1_word_nxt.data_byte = lowered;
    s1_word_nxt.take      = !in_ch.no_byte && !(normalize && fnv_pkg::is_skipped(lowered));
    s1_word_nxt.last      = in_ch.last;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (ctrl.advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r <= s1_word_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_word  = s1_word_r;

endmodule

// File: rtl/fnv_core.sv
// hash stage: running fnv-1a update and the result register
module fnv_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s1_valid,
  input  fnv_pkg::stage_word_t s1_word,
  output fnv_pkg::stage_ctrl_t ctrl,
  fnv_out_if.source            out_ch
);

  logic [63:0] hash_r;
  logic [63:0] hash_nxt;
  logic [63:0] hash_upd;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [63:0] out_hash_r;
  logic        advance;
  logic        emit;

  assign advance      = s1_valid && !(s1_word.last && out_valid_r && !out_ch.ready);
  assign ctrl.advance = advance;
  assign emit         = advance && s1_word.last;

  always_comb begin
    hash_upd = hash_r;
    if (s1_word.take) begin
      hash_upd = fnv_pkg::mul_prime(hash_r ^ {56'd0, s1_word.data_byte});
    end
    hash_nxt = hash_r;
    if (advance) begin
      hash_nxt = s1_word.last ? fnv_pkg::OFFSET_BASIS : hash_upd;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= fnv_pkg::OFFSET_BASIS;
      out_valid_r <= 1'b0;
    end else begin
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_hash_r <= hash_upd;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hash_value = out_hash_r;

endmodule

// File: tb/fnv1a64_string_hash_test.sv
// self-checking testbench for the fnv-1a 64-bit string hash
`timescale 1ns / 100ps

module fnv1a64_string_hash_test;

  localparam logic [63:0] HASH_MULT = 64'h100000001b3;
  localparam logic [fnv_pkg::CFG_ADDR_W-1:0] NORMALIZE_ADDR =
    fnv_pkg::CFG_ADDR_W'(4 * fnv_pkg::REG_NORMALIZE);
  localparam int unsigned PHASE_WORDS = 135;
  localparam int unsigned PHASES = 6;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int DIRECTED_ROWS = 26;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [7:0]  data_byte;
    logic        no_byte;
    logic        last;
    logic        norm;
    logic        typed;
    logic [63:0] hash;
  } stim_row_t;

  stim_row_t directed [DIRECTED_ROWS] = '{
    '{ROW_CFG,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1, fnv_pkg::OFFSET_BASIS},
    '{ROW_WORD, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 8'hff, 1'b1, 1'b1, 1'b0, 1'b1, fnv_pkg::OFFSET_BASIS},
    '{ROW_WORD, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 8'hff, 1'b0, 1'b1, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 8'h41, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 8'h62, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 8'h20, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 8'h21, 1'b0, 1'b1, 1'b0, 1'b0, 64'd0},
    '{ROW_CFG,  8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 64'd0},
    '{ROW_WORD, 8'h41, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 8'h5a, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 8'h09, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 8'h0d, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 8'h20, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 8'h2f, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 8'h7e, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 8'h08, 1'b0, 1'b1, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 8'h20, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 8'h21, 1'b0, 1'b1, 1'b0, 1'b1, fnv_pkg::OFFSET_BASIS},
    '{ROW_WORD, 8'h61, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
    '{ROW_CFG,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 8'h42, 1'b0, 1'b1, 1'b0, 1'b0, 64'd0}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [fnv_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  fnv_in_if  in_ch ();
  fnv_out_if out_ch ();

  fnv1a64_string_hash i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  logic [63:0] running_hash = fnv_pkg::OFFSET_BASIS;
  logic        normalize_shadow = 1'b0;
  logic [63:0] pending_hashes [$];
  int unsigned words_sent = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  logic        hold_out = 1'b0;
  logic        tail_quiet = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // fold one word into the running hash; returns 1 when a hash is complete
  function automatic logic hash_word(input logic [7:0] b, input logic nb, input logic lst,
                                     output logic [63:0] done);
    logic [7:0] c;
    logic       keep;
    c = b;
    keep = !nb;
    if (keep && normalize_shadow) begin
      if (c >= 8'h41 && c <= 8'h5a) begin
        c = c | 8'h20;
      end
      if ((c >= 8'h09 && c <= 8'h0d) || (c >= 8'h20 && c <= 8'h2f) ||
          (c >= 8'h3a && c <= 8'h40) || (c >= 8'h5b && c <= 8'h60) ||
          (c >= 8'h7b && c <= 8'h7e)) begin
        keep = 1'b0;
      end
    end
    if (keep) begin
      running_hash = (running_hash ^ {56'd0, c}) * HASH_MULT;
    end
    done = running_hash;
    if (lst) begin
      running_hash = fnv_pkg::OFFSET_BASIS;
    end
    return lst;
  endfunction

  task automatic send_word(input logic [7:0] b, input logic nb, input logic lst,
                           input logic typed, input logic [63:0] typed_hash);
    logic [63:0] predicted;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.data_byte = b;
    in_ch.no_byte = nb;
    in_ch.last = lst;
    do @(posedge clk); while (!in_ch.ready);
    if (hash_word(b, nb, lst, predicted)) begin
      pending_hashes.push_back(typed ? typed_hash : predicted);
    end
    if (!nb || lst) begin
      words_sent++;
    end
  endtask

  task automatic pause_in(input int unsigned n);
    @(negedge clk);
    in_ch.valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [fnv_pkg::CFG_ADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = wr;
    cfg_paddr = addr;
    cfg_pwdata = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic set_normalize(input logic v);
    logic [31:0] rdata;
    pause_in(1);
    wait_drained();
    cfg_access(1'b1, NORMALIZE_ADDR, 32'(v), rdata);
    normalize_shadow = v;
    cfg_access(1'b0, NORMALIZE_ADDR, 32'd0, rdata);
    if (rdata !== 32'(v)) begin
      $error("normalize expected %h actual %h", 32'(v), rdata);
      mismatches++;
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 4))
      0: return 8'($urandom_range(0, 255));
      1: return 8'($urandom_range(8'h41, 8'h5a));
      2: return 8'($urandom_range(8'h61, 8'h7a));
      3: return 8'($urandom_range(8'h20, 8'h7e));
      default: return 8'($urandom_range(8'h08, 8'h0e));
    endcase
  endfunction

  task automatic send_string();
    int unsigned len;
    logic        gappy;
    logic        end_empty;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
    gappy = !tail_quiet && ($urandom_range(0, 2) != 0);
    end_empty = (len == 0) || ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      // stray idle words between bytes
      if ($urandom_range(0, 19) == 0) begin
        send_word(pick_byte(), 1'b1, 1'b0, 1'b0, 64'd0);
      end
      send_word(pick_byte(), 1'b0, !end_empty && (i == len - 1), 1'b0, 64'd0);
      if (gappy && $urandom_range(0, 5) == 0) begin
        pause_in($urandom_range(1, 17));
      end
    end
    if (end_empty) begin
      send_word(pick_byte(), 1'b1, 1'b1, 1'b0, 64'd0);
    end
  endtask

  initial begin
    logic paused;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.no_byte = 1'b0;
    in_ch.last = 1'b0;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        set_normalize(directed[i].norm);
      end else begin
        send_word(directed[i].data_byte, directed[i].no_byte, directed[i].last,
                  directed[i].typed, directed[i].hash);
      end
    end

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: ;
        1: set_normalize(1'b1);
        2: set_normalize(1'b0);
        3: set_normalize(1'b1);
        default: set_normalize(1'($urandom_range(0, 1)));
      endcase
      if (phase == PHASES - 1) begin
        tail_quiet = 1'b1;
      end
      if (phase == 2) begin
        hold_out = 1'b1;
      end
      while (words_sent < (phase + 1) * PHASE_WORDS) begin
        send_string();
        if (phase == 3 && !paused && words_sent >= 3 * PHASE_WORDS + 60) begin
          pause_in(1);
          while (pending_hashes.size() != 0) @(posedge clk);
          paused = 1'b1;
        end
      end
      // leave a string open across the register change
      if (phase < PHASES - 1) begin
        repeat ($urandom_range(0, 3)) send_word(pick_byte(), 1'b0, 1'b0, 1'b0, 64'd0);
      end
    end

    pause_in(1);
    wait_drained();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : sink_side
    int unsigned n;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out = 1'b0;
      end else if (!tail_quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        n = $urandom_range(1, 17);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
        n = $urandom_range(1, 24);
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : hash_check
    logic [63:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_hashes.size() == 0) begin
        $error("hash_value expected none actual %h", out_ch.hash_value);
        mismatches++;
      end else begin
        want = pending_hashes.pop_front();
        if (out_ch.hash_value !== want) begin
          $error("hash_value expected %h actual %h", want, out_ch.hash_value);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: filelist.f
rtl/fnv_pkg.sv
rtl/fnv_if.sv
rtl/fnv_norm.sv
rtl/fnv_core.sv
rtl/fnv1a64_string_hash.sv
tb/fnv1a64_string_hash_test.sv
